/* hw/rtl/gb3_pkg.sv */
package gb3_pkg;

   // pixel and register field widths
   localparam int PIXEL_W    = 8;
   localparam int COLS_W     = 12;
   localparam int ROWS_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS    = 2'd1;

   // register reset values
   localparam logic [COLS_W-1:0] COLS_RESET = 12'd2048;
   localparam logic [ROWS_W-1:0] ROWS_RESET = 16'd1;

endpackage

/* hw/rtl/gaussian_blur_3x3_stream.sv */
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_pixel_in
// rsp      out        rsp_valid/rsp_stall  rsp_pixel_out, rsp_frame_end
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// one pixel beat per clock sustained while rsp_stall is low; a result passes the line store
// read register, the window register and the output register
// after reset a clearing pass zeroes every line store word, req_stall high
// csr writes are taken in every cycle, including during the clearing pass
// rsp_stall backs up through three stages; beats are still taken until all three are full

module gaussian_blur_3x3_stream
   import gb3_pkg::*;
#(
   parameter int LINE_DEPTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pixel_type             req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pixel_type             rsp_pixel_out,
   output logic                  rsp_frame_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW   = $clog2(LINE_DEPTH);
   localparam int CW   = AW + 1;
   localparam int CMPW = (CW > COLS_W) ? CW : COLS_W;
   localparam int WW   = 2 * PIXEL_W;
   localparam int SW   = PIXEL_W + 4;

   // config registers
   logic [COLS_W-1:0] cols_ff, cols_in;
   logic [ROWS_W-1:0] rows_ff, rows_in;

   // effective geometry
   logic [CMPW-1:0]   cols_wide, cols_lim;
   logic [CW-1:0]     cols_eff;
   logic [ROWS_W-1:0] rows_eff;

   // position counters
   logic [AW-1:0]     col_ff, col_in;
   logic [ROWS_W-1:0] row_ff, row_in;
   logic [CW-1:0]     col_wide, col_plus, col_clamp;
   logic [ROWS_W:0]   row_plus;
   logic              last_col, last_row;
   logic [AW-1:0]     acc_addr;
   logic              accept;

   // handshake enables
   logic en_out, en2, en1;

   // clearing pass
   logic          clear_ff, clear_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;

   // line store, word is {older, newer}
   logic [WW-1:0] line_mem [LINE_DEPTH];
   logic [WW-1:0] line_q_ff;
   logic [WW-1:0] line_cur, wr_word;
   logic          fwd_v_ff, fwd_v_in;
   logic [WW-1:0] fwd_word_ff, fwd_word_in;

   // stage 1: line store data present
   logic          s1_v_ff, s1_v_in;
   logic [AW-1:0] s1_addr_ff;
   pixel_type     s1_pixel_ff;
   logic          s1_end_ff;
   logic          s1_write;

   // stage 2: window holds this beat
   logic      s2_v_ff, s2_v_in;
   logic      s2_end_ff;
   pixel_type win_ff [3][3];
   logic [SW-1:0] sum;

   // output register
   logic      out_v_ff, out_v_in;
   pixel_type out_pix_ff;
   logic      out_end_ff;

   // config write decode
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_COLUMNS: cols_in = csr_data[COLS_W-1:0];
            CSR_IMAGE_ROWS:    rows_in = csr_data[ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // clamp columns to 1..LINE_DEPTH, rows to at least 1
   always_comb begin
      cols_wide = CMPW'(cols_ff);
      if (cols_wide == '0) begin
         cols_lim = CMPW'(1);
      end else if (cols_wide > CMPW'(LINE_DEPTH)) begin
         cols_lim = CMPW'(LINE_DEPTH);
      end else begin
         cols_lim = cols_wide;
      end
      cols_eff = cols_lim[CW-1:0];
      rows_eff = (rows_ff == '0) ? ROWS_W'(1) : rows_ff;
   end

   // handshake chain from the output back to the input
   assign en_out    = !out_v_ff || !rsp_stall;
   assign en2       = !s2_v_ff || en_out;
   assign en1       = !s1_v_ff || en2;
   assign req_stall = clear_ff || !en1;
   assign accept    = req_valid && !req_stall;
   assign s1_write  = s1_v_ff && en2;

   // column and row position, past-the-end counts as last
   always_comb begin
      col_wide  = {1'b0, col_ff};
      col_plus  = col_wide + CW'(1);
      col_clamp = (col_wide >= cols_eff) ? (cols_eff - CW'(1)) : col_wide;
      acc_addr  = col_clamp[AW-1:0];
      last_col  = (col_plus >= cols_eff);
      row_plus  = {1'b0, row_ff} + (ROWS_W+1)'(1);
      last_row  = (row_plus >= {1'b0, rows_eff});
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_plus[ROWS_W-1:0];
         end else begin
            col_in = col_plus[AW-1:0];
         end
      end
   end

   // clearing pass sequencing
   always_comb begin
      clear_in      = clear_ff && (clear_addr_ff != AW'(LINE_DEPTH - 1));
      clear_addr_in = clear_ff ? (clear_addr_ff + AW'(1)) : clear_addr_ff;
   end

   // line data with forwarding of the write that raced this read
   always_comb begin
      line_cur    = fwd_v_ff ? fwd_word_ff : line_q_ff;
      wr_word     = {line_cur[PIXEL_W-1:0], s1_pixel_ff};
      fwd_v_in    = fwd_v_ff;
      fwd_word_in = fwd_word_ff;
      if (accept) begin
         fwd_v_in    = s1_write && (acc_addr == s1_addr_ff);
         fwd_word_in = wr_word;
      end
   end

   // stage valids
   always_comb begin
      s1_v_in  = accept ? 1'b1 : (en2 ? 1'b0 : s1_v_ff);
      s2_v_in  = s1_write ? 1'b1 : (en_out ? 1'b0 : s2_v_ff);
      out_v_in = en_out ? s2_v_ff : out_v_ff;
   end

   // weighted 1-2-1 / 2-4-2 / 1-2-1 sum
   always_comb begin
      sum = SW'(win_ff[0][0]) + SW'({win_ff[0][1], 1'b0})
          + SW'(win_ff[0][2]) + SW'({win_ff[1][0], 1'b0})
          + SW'({win_ff[1][1], 2'b00}) + SW'({win_ff[1][2], 1'b0})
          + SW'(win_ff[2][0]) + SW'({win_ff[2][1], 1'b0})
          + SW'(win_ff[2][2]);
   end

   // line store port
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         line_mem[clear_addr_ff] <= '0;
      end else if (s1_write) begin
         line_mem[s1_addr_ff] <= wr_word;
      end
      if (accept) begin
         line_q_ff <= line_mem[acc_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff       <= COLS_RESET;
         rows_ff       <= ROWS_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         fwd_v_ff      <= 1'b0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         cols_ff       <= cols_in;
         rows_ff       <= rows_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         fwd_v_ff      <= fwd_v_in;
         s1_v_ff       <= s1_v_in;
         s2_v_ff       <= s2_v_in;
         out_v_ff      <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fwd_word_ff <= fwd_word_in;
      if (accept) begin
         s1_addr_ff  <= acc_addr;
         s1_pixel_ff <= req_pixel_in;
         s1_end_ff   <= last_col && last_row;
      end
      if (s1_write) begin
         s2_end_ff <= s1_end_ff;
      end
      if (en_out && s2_v_ff) begin
         out_pix_ff <= sum[SW-1:4];
         out_end_ff <= s2_end_ff;
      end
   end

   // window shifts left, right column from the line store and the new pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (s1_write) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= line_cur[WW-1:PIXEL_W];
         win_ff[1][2] <= line_cur[PIXEL_W-1:0];
         win_ff[2][2] <= s1_pixel_ff;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_pixel_out = out_pix_ff;
   assign rsp_frame_end = out_end_ff;

endmodule

/* hw/rtl/gb3_checker.sv */
module gb3_checker
   import gb3_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input pixel_type             req_pixel_in,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input pixel_type             rsp_pixel_out,
   input logic                  rsp_frame_end,
   input logic                  csr_valid,
   input logic                  csr_ready
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
                                 && $stable(rsp_frame_end))
      else $error("result beat changed while stalled");

   // a stalled pixel beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_pixel_in))
      else $error("pixel beat changed while stalled");

   // clearing pass holds off input right after reset
   a_clear_stall: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("input taken before line store clearing");

   // no result out of reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

   // register writes are always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write held off");

endmodule

bind gaussian_blur_3x3_stream gb3_checker u_gb3_checker (.*);
